/* hw/rtl/lgsr_pkg.sv */
package lgsr_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_START   = 2'd1,
        FUNC_ADVANCE = 2'd2,
        FUNC_FINISH  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_CLIP_X_LOW   = 3'd0,
        REG_CLIP_X_HIGH  = 3'd1,
        REG_CLIP_Y_LOW   = 3'd2,
        REG_CLIP_Y_HIGH  = 3'd3,
        REG_SWAP_AXES    = 3'd4,
        REG_COMP_COUNT   = 3'd5,
        REG_COMP_WIDTH   = 3'd6,
        REG_COMP_OFFSET  = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PACK,
        ST_EMIT,
        ST_OUT
    } state_t;

    localparam int unsigned COLOR_BITS = 31;
    localparam int unsigned NUM_BITS   = 32;
    localparam int unsigned CIDX_BITS  = 64;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 24;

    // Divider handshake group
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* hw/rtl/lgsr_if.sv */
interface lgsr_in_if #(
    parameter int COORD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [1:0]                    component_index;
    logic [30:0]                   start_color;
    logic [30:0]                   start_fraction;
    logic signed [31:0]            step_numerator;
    logic [30:0]                   step_denominator;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  row;
    logic [COORD_BITS-1:0]         span_width;

    modport source (output valid, func, component_index, start_color, start_fraction,
                    step_numerator, step_denominator, start_x, row, span_width,
                    input ready);
    modport sink (input valid, func, component_index, start_color, start_fraction,
                  step_numerator, step_denominator, start_x, row, span_width,
                  output ready);
endinterface

interface lgsr_out_if #(
    parameter int COORD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  rect_x;
    logic signed [COORD_BITS-1:0]  rect_y;
    logic [COORD_BITS-1:0]         rect_width;
    logic [COORD_BITS-1:0]         rect_height;
    logic [63:0]                   color_index;

    modport source (output valid, rect_x, rect_y, rect_width, rect_height, color_index,
                    input ready);
    modport sink (input valid, rect_x, rect_y, rect_width, rect_height, color_index,
                  output ready);
endinterface

interface lgsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/lgsr_floor_div.sv */
// Radix-2 restoring floor division of a signed 32-bit dividend by a positive
// 31-bit divisor, one quotient bit per cycle.
module lgsr_floor_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lgsr_pkg::div_ctrl_t      ctrl,
    input  logic signed [31:0]       dividend,
    input  logic [30:0]              divisor,
    output lgsr_pkg::div_stat_t      stat,
    output logic signed [31:0]       quotient,
    output logic [30:0]              remainder
);
    logic [5:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] den_reg, den_next;
    logic [31:0] trial;
    logic [32:0] diff;
    logic [31:0] q_mag;
    logic [31:0] r_mag;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg[30:0], quo_reg[31]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
    end

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        if (ctrl.start)
        begin
            busy_next  = 1'b1;
            count_next = 6'd32;
            neg_next   = dividend[31];
            quo_next   = dividend[31] ? 32'(-dividend) : 32'(dividend);
            rem_next   = '0;
            den_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (diff[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            count_next = count_reg - 6'd1;
            if (count_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // Fold sign back in with floor correction
    always_comb
    begin
        q_mag = quo_reg;
        r_mag = rem_reg;
        if (!neg_reg)
        begin
            quotient  = q_mag;
            remainder = r_mag[30:0];
        end
        else if (r_mag == '0)
        begin
            quotient  = 32'(-q_mag);
            remainder = '0;
        end
        else
        begin
            quotient  = 32'(-q_mag) - 32'sd1;
            remainder = 31'({1'b0, den_reg} - r_mag);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

/* hw/rtl/linear_gradient_scanline_runs_unit.sv */
// An advance word on a visible row runs each component in use through the shared
// divider (a start state, the quotient steps, then collecting the result) and then
// packs each component, between the accept and emit states.
// Start packs the components and emits, finish emits, load only writes registers; one word in flight at a time,
// and a waiting rectangle holds off the next word until taken.
// Reset clears the accumulators, registers and control state; no clearing pass.
module linear_gradient_scanline_runs_unit #(
    parameter int MAX_COMPONENTS = 4,
    parameter int COORD_BITS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lgsr_in_if.sink   in_ch,
    lgsr_out_if.source out_ch,
    lgsr_cfg_if.sink  cfg
);
    localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int EW = COORD_BITS + 1;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // Configuration registers
    logic signed [15:0] clip_x_low_reg, clip_x_high_reg, clip_y_low_reg, clip_y_high_reg;
    logic        swap_axes_reg;
    logic [2:0]  comp_count_reg;
    logic [19:0] comp_width_reg;
    logic [23:0] comp_offset_reg;

    // Datapath state
    logic [30:0]        color_reg  [MAX_COMPONENTS];
    logic [30:0]        rem_reg    [MAX_COMPONENTS];
    logic [31:0]        step_reg   [MAX_COMPONENTS];
    logic [30:0]        den_reg;
    logic signed [COORD_BITS-1:0] pos_reg, run_start_reg, row_reg;
    logic [63:0]        run_color_reg;
    logic               visible_reg;

    lgsr_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      comp_reg;
    logic [3:0]         used;
    logic [63:0]        packed_reg;
    logic               pack_is_start_reg;
    logic               finish_reg;

    // Output word register
    logic               out_valid_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;
    logic [COORD_BITS-1:0] ow_reg, oh_reg;
    logic [63:0]        oc_reg;

    lgsr_pkg::div_ctrl_t dctrl;
    lgsr_pkg::div_stat_t dstat;
    logic signed [31:0]  dquo;
    logic [30:0]         drem;
    logic signed [31:0]  dividend;

    logic accept;
    logic [63:0] pack_val;
    logic last_comp;

    assign used = ({1'b0, comp_count_reg} > 4'(MAX_COMPONENTS)) ? 4'(MAX_COMPONENTS)
                                                                 : {1'b0, comp_count_reg};
    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == lgsr_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign last_comp = (4'(comp_reg) + 4'd1) >= used;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_x_low_reg  <= '0;
            clip_x_high_reg <= '0;
            clip_y_low_reg  <= '0;
            clip_y_high_reg <= '0;
            swap_axes_reg   <= 1'b0;
            comp_count_reg  <= 3'd1;
            comp_width_reg  <= 20'd8;
            comp_offset_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (lgsr_pkg::reg_index_t'(cfg.index))
                lgsr_pkg::REG_CLIP_X_LOW:  clip_x_low_reg  <= cfg.data[15:0];
                lgsr_pkg::REG_CLIP_X_HIGH: clip_x_high_reg <= cfg.data[15:0];
                lgsr_pkg::REG_CLIP_Y_LOW:  clip_y_low_reg  <= cfg.data[15:0];
                lgsr_pkg::REG_CLIP_Y_HIGH: clip_y_high_reg <= cfg.data[15:0];
                lgsr_pkg::REG_SWAP_AXES:   swap_axes_reg   <= cfg.data[0];
                lgsr_pkg::REG_COMP_COUNT:  comp_count_reg  <= cfg.data[2:0];
                lgsr_pkg::REG_COMP_WIDTH:  comp_width_reg  <= cfg.data[19:0];
                lgsr_pkg::REG_COMP_OFFSET: comp_offset_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Pack one component per cycle into the colour index
    always_comb
    begin
        logic [4:0]  bits;
        logic [5:0]  sh;
        logic [30:0] top;
        bits = 5'(comp_width_reg >> (5 * int'(comp_reg)));
        sh   = 6'(comp_offset_reg >> (6 * int'(comp_reg)));
        top  = color_reg[comp_reg] >> (5'd31 - bits);
        pack_val = packed_reg | (64'(top) << sh);
    end

    assign dividend = 32'(rem_reg[comp_reg]) + step_reg[comp_reg];
    assign dctrl.start = (state_reg == lgsr_pkg::ST_DIV_START);

    lgsr_floor_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dctrl),
        .dividend  (dividend),
        .divisor   (den_reg),
        .stat      (dstat),
        .quotient  (dquo),
        .remainder (drem)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lgsr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_ch.func == lgsr_pkg::FUNC_START)
                        state_next = (used == 4'd0) ? lgsr_pkg::ST_EMIT : lgsr_pkg::ST_PACK;
                    else if (in_ch.func == lgsr_pkg::FUNC_ADVANCE && visible_reg
                             && pos_reg < COORD_MAX)
                        state_next = (used == 4'd0) ? lgsr_pkg::ST_EMIT
                                                    : lgsr_pkg::ST_DIV_START;
                    else if (in_ch.func == lgsr_pkg::FUNC_FINISH && visible_reg)
                        state_next = lgsr_pkg::ST_EMIT;
                    else
                        state_next = lgsr_pkg::ST_IDLE;
                end
            end
            lgsr_pkg::ST_DIV_START: state_next = lgsr_pkg::ST_DIV_WAIT;
            lgsr_pkg::ST_DIV_WAIT:
                if (dstat.done)
                    state_next = last_comp ? lgsr_pkg::ST_PACK : lgsr_pkg::ST_DIV_START;
            lgsr_pkg::ST_PACK:
                if (last_comp)
                    state_next = lgsr_pkg::ST_EMIT;
            lgsr_pkg::ST_EMIT: state_next = lgsr_pkg::ST_IDLE;
            default: state_next = lgsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lgsr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Emit helper: clip the run and form a rectangle; one spare bit lets the
    // run end just past the largest column
    logic signed [EW-1:0] end_x, si, ei, xl, xh;
    logic        do_emit;
    logic [63:0] ci_now;
    always_comb
    begin
        xl = EW'(clip_x_low_reg);
        xh = EW'(clip_x_high_reg);
        ci_now = (used == 4'd0) ? 64'd0 : packed_reg;
        end_x = finish_reg ? EW'(pos_reg) + EW'(1) : EW'(pos_reg);
        si = (EW'(run_start_reg) > xl) ? EW'(run_start_reg) : xl;
        ei = (end_x < xh) ? end_x : xh;
        do_emit = (finish_reg || ci_now != run_color_reg) && (si < ei);
    end

    // Sequencer datapath actions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_COMPONENTS; k++)
            begin
                color_reg[k] <= '0;
                rem_reg[k]   <= '0;
                step_reg[k]  <= '0;
            end
            den_reg           <= 31'd1;
            pos_reg           <= '0;
            run_start_reg     <= '0;
            row_reg           <= '0;
            run_color_reg     <= '0;
            visible_reg       <= 1'b0;
            comp_reg          <= '0;
            packed_reg        <= '0;
            pack_is_start_reg <= 1'b0;
            finish_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            ox_reg            <= '0;
            oy_reg            <= '0;
            ow_reg            <= '0;
            oh_reg            <= '0;
            oc_reg            <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                lgsr_pkg::ST_IDLE:
                begin
                    comp_reg   <= '0;
                    packed_reg <= '0;
                    if (accept)
                    begin
                        finish_reg        <= (in_ch.func == lgsr_pkg::FUNC_FINISH);
                        pack_is_start_reg <= (in_ch.func == lgsr_pkg::FUNC_START);
                        unique case (lgsr_pkg::func_t'(in_ch.func))
                            lgsr_pkg::FUNC_LOAD:
                                if (int'(in_ch.component_index) < MAX_COMPONENTS)
                                begin
                                    color_reg[CW'(in_ch.component_index)] <= in_ch.start_color;
                                    rem_reg[CW'(in_ch.component_index)] <= in_ch.start_fraction;
                                    step_reg[CW'(in_ch.component_index)] <= in_ch.step_numerator;
                                end
                            lgsr_pkg::FUNC_START:
                            begin
                                den_reg <= (in_ch.step_denominator == '0) ? 31'd1
                                                                          : in_ch.step_denominator;
                                pos_reg       <= in_ch.start_x;
                                run_start_reg <= in_ch.start_x;
                                row_reg       <= in_ch.row;
                                visible_reg   <= !(in_ch.row < COORD_BITS'(clip_y_low_reg) ||
                                                   in_ch.row > COORD_BITS'(clip_y_high_reg));
                            end
                            lgsr_pkg::FUNC_ADVANCE:
                                if (visible_reg && pos_reg < COORD_MAX)
                                    pos_reg <= pos_reg + COORD_BITS'(1);
                            lgsr_pkg::FUNC_FINISH: ;
                            default: ;
                        endcase
                    end
                end
                lgsr_pkg::ST_DIV_WAIT:
                    if (dstat.done)
                    begin
                        color_reg[comp_reg] <= color_reg[comp_reg] + dquo[30:0];
                        rem_reg[comp_reg]   <= drem;
                        comp_reg <= last_comp ? '0 : comp_reg + 1'b1;
                    end
                lgsr_pkg::ST_PACK:
                begin
                    packed_reg <= pack_val;
                    comp_reg   <= comp_reg + 1'b1;
                end
                lgsr_pkg::ST_EMIT:
                begin
                    if (pack_is_start_reg)
                        run_color_reg <= ci_now;
                    else
                    begin
                        if (do_emit)
                        begin
                            out_valid_reg <= 1'b1;
                            ox_reg <= swap_axes_reg ? row_reg : COORD_BITS'(si);
                            oy_reg <= swap_axes_reg ? COORD_BITS'(si) : row_reg;
                            ow_reg <= swap_axes_reg ? COORD_BITS'(1) : COORD_BITS'(ei - si);
                            oh_reg <= swap_axes_reg ? COORD_BITS'(ei - si) : COORD_BITS'(1);
                            oc_reg <= run_color_reg;
                        end
                        if (finish_reg)
                            visible_reg <= 1'b0;
                        else if (ci_now != run_color_reg)
                        begin
                            run_start_reg <= pos_reg;
                            run_color_reg <= ci_now;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.rect_x      = ox_reg;
    assign out_ch.rect_y      = oy_reg;
    assign out_ch.rect_width  = ow_reg;
    assign out_ch.rect_height = oh_reg;
    assign out_ch.color_index = oc_reg;

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != lgsr_pkg::ST_IDLE |-> !in_ch.ready)
        else $error("input taken while sequencer busy");
    a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.done |-> state_reg == lgsr_pkg::ST_DIV_WAIT)
        else $error("divider finished outside wait state");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(oc_reg))
        else $error("result word dropped");
    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ow_reg != '0 && oh_reg != '0)
        else $error("empty rectangle emitted");
endmodule

/* dv/linear_gradient_scanline_runs_unit_tb.sv */
module linear_gradient_scanline_runs_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        lgsr_pkg::func_t func;
        logic [1:0]  comp;
        logic [30:0] colour;
        logic [30:0] fraction;
        logic [31:0] numerator;
        logic [30:0] denom;
        logic [15:0] start_x;
        logic [15:0] row;
        logic [15:0] span;
    } grad_word_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [63:0] cidx;
    } rect_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lgsr_in_if  #(.COORD_BITS(16)) in_ch ();
    lgsr_out_if #(.COORD_BITS(16)) out_ch ();
    lgsr_cfg_if cfg ();

    linear_gradient_scanline_runs_unit #(.MAX_COMPONENTS(4), .COORD_BITS(16)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always #4 clk = ~clk;

    // gradient state mirrored from the block
    logic [15:0] clip_xl, clip_xh, clip_yl, clip_yh;
    logic        swap_xy;
    logic [2:0]  comp_count;
    logic [19:0] comp_widths;
    logic [23:0] comp_offsets;
    logic [30:0] colour_acc [4];
    logic [31:0] rem_acc [4];
    logic [31:0] step_num [4];
    logic [30:0] denom;
    int          pixel_pos, run_start, cur_row;
    logic [63:0] run_colour;
    bit          row_visible;

    grad_word_t word_queue [$];
    rect_t      pending_rects [$];
    grad_word_t held_word;
    int         tx_gap, rx_gap, hold_cnt;
    bit         hold_arm, hold_done, burst;
    int         errors, words_sent, rects_seen, scanlines;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h, want %h (rect %0d)", what, got, want, rects_seen);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] pack_index();
        logic [63:0] ci;
        int          used;
        int          nb, sh;
        ci = '0;
        used = (comp_count > 4) ? 4 : comp_count;
        for (int k = 0; k < used; k++) begin
            nb = comp_widths[5*k +: 5];
            sh = comp_offsets[6*k +: 6];
            ci |= (64'(colour_acc[k] >> (31 - nb))) << sh;
        end
        return ci;
    endfunction

    function automatic void step_colours();
        logic [31:0] s;
        longint      m, q, r, d;
        int          used;
        used = (comp_count > 4) ? 4 : comp_count;
        d = longint'(denom);
        for (int k = 0; k < used; k++) begin
            s = rem_acc[k] + step_num[k];
            m = longint'($signed(s));
            q = m / d;
            r = m - q * d;
            if (r < 0) begin
                q -= 1;
                r += d;
            end
            colour_acc[k] = colour_acc[k] + q[30:0];
            rem_acc[k] = r[31:0];
        end
    endfunction

    // clip the run [run_start, stop) and queue a rectangle if anything is left
    function automatic void clip_run(input int stop);
        int    lo, hi;
        rect_t rc;
        lo = (run_start > int'($signed(clip_xl))) ? run_start : int'($signed(clip_xl));
        hi = (stop < int'($signed(clip_xh))) ? stop : int'($signed(clip_xh));
        if (lo >= hi) return;
        if (swap_xy) begin
            rc.x = cur_row[15:0];
            rc.y = lo[15:0];
            rc.w = 16'd1;
            rc.h = 16'(hi - lo);
        end else begin
            rc.x = lo[15:0];
            rc.y = cur_row[15:0];
            rc.w = 16'(hi - lo);
            rc.h = 16'd1;
        end
        rc.cidx = run_colour;
        pending_rects.push_back(rc);
    endfunction

    function automatic void predict_runs(input grad_word_t w);
        logic [63:0] ci;
        case (w.func)
            lgsr_pkg::FUNC_LOAD:
            begin
                colour_acc[w.comp] = w.colour;
                rem_acc[w.comp] = {1'b0, w.fraction};
                step_num[w.comp] = w.numerator;
            end
            lgsr_pkg::FUNC_START:
            begin
                denom = (w.denom == 0) ? 31'd1 : w.denom;
                pixel_pos = int'($signed(w.start_x));
                run_start = pixel_pos;
                cur_row = int'($signed(w.row));
                run_colour = pack_index();
                row_visible = !(cur_row < int'($signed(clip_yl)) ||
                                cur_row > int'($signed(clip_yh)));
            end
            lgsr_pkg::FUNC_ADVANCE:
            begin
                if (row_visible && pixel_pos < 32767) begin
                    step_colours();
                    pixel_pos++;
                    ci = pack_index();
                    if (ci != run_colour) begin
                        clip_run(pixel_pos);
                        run_start = pixel_pos;
                        run_colour = ci;
                    end
                end
            end
            default:
            begin
                if (row_visible) begin
                    row_visible = 0;
                    clip_run(pixel_pos + 1);
                end
            end
        endcase
    endfunction

    // driver: present queued words, idle between them at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_runs(held_word);
                words_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end else if (word_queue.size() > 0) begin
                    held_word = word_queue.pop_front();
                    in_ch.func <= held_word.func;
                    in_ch.component_index <= held_word.comp;
                    in_ch.start_color <= held_word.colour;
                    in_ch.start_fraction <= held_word.fraction;
                    in_ch.step_numerator <= held_word.numerator;
                    in_ch.step_denominator <= held_word.denom;
                    in_ch.start_x <= held_word.start_x;
                    in_ch.row <= held_word.row;
                    in_ch.span_width <= held_word.span;
                    in_ch.valid <= 1'b1;
                    tx_gap = pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, counted on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_cnt <= 600;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor: take rectangles and check them against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        rect_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                rects_seen++;
                if (pending_rects.size() == 0) begin
                    report_mismatch("unexpected rect", out_ch.color_index, '0);
                end else begin
                    want = pending_rects.pop_front();
                    if (out_ch.rect_x !== want.x) report_mismatch("rect_x", out_ch.rect_x, want.x);
                    if (out_ch.rect_y !== want.y) report_mismatch("rect_y", out_ch.rect_y, want.y);
                    if (out_ch.rect_width !== want.w)
                        report_mismatch("rect_width", out_ch.rect_width, want.w);
                    if (out_ch.rect_height !== want.h)
                        report_mismatch("rect_height", out_ch.rect_height, want.h);
                    if (out_ch.color_index !== want.cidx)
                        report_mismatch("color_index", out_ch.color_index, want.cidx);
                end
            end
            if (rx_gap > 0) rx_gap--;
            else rx_gap = pick_gap();
            out_ch.ready <= (hold_cnt == 0) && (rx_gap == 0);
        end
    end

    function automatic grad_word_t rand_word();
        grad_word_t w;
        w.func = lgsr_pkg::func_t'($urandom_range(0, 3));
        w.comp = 2'($urandom);
        w.colour = 31'($urandom);
        w.fraction = 31'($urandom);
        w.numerator = $urandom;
        w.denom = 31'($urandom);
        w.start_x = 16'($urandom);
        w.row = 16'($urandom);
        w.span = 16'($urandom);
        return w;
    endfunction

    task automatic push_load(input int k, input logic [30:0] c, input logic [30:0] f,
                             input logic [31:0] n);
        grad_word_t w;
        w = rand_word();
        w.func = lgsr_pkg::FUNC_LOAD;
        w.comp = 2'(k);
        w.colour = c;
        w.fraction = f;
        w.numerator = n;
        word_queue.push_back(w);
    endtask

    task automatic push_start(input logic [30:0] d, input int x, input int r);
        grad_word_t w;
        w = rand_word();
        w.func = lgsr_pkg::FUNC_START;
        w.denom = d;
        w.start_x = 16'(x);
        w.row = 16'(r);
        word_queue.push_back(w);
    endtask

    task automatic push_cmd(input lgsr_pkg::func_t f, input int n);
        grad_word_t w;
        repeat (n)
        begin
            w = rand_word();
            w.func = f;
            word_queue.push_back(w);
        end
    endtask

    task automatic cfg_write(input lgsr_pkg::reg_index_t idx, input logic [23:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(negedge clk); while (!cfg.ready);
        @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            lgsr_pkg::REG_CLIP_X_LOW:  clip_xl = val[15:0];
            lgsr_pkg::REG_CLIP_X_HIGH: clip_xh = val[15:0];
            lgsr_pkg::REG_CLIP_Y_LOW:  clip_yl = val[15:0];
            lgsr_pkg::REG_CLIP_Y_HIGH: clip_yh = val[15:0];
            lgsr_pkg::REG_SWAP_AXES:   swap_xy = val[0];
            lgsr_pkg::REG_COMP_COUNT:  comp_count = val[2:0];
            lgsr_pkg::REG_COMP_WIDTH:  comp_widths = val[19:0];
            default:                   comp_offsets = val;
        endcase
    endtask

    task automatic set_config(input int xl, input int xh, input int yl, input int yh,
                              input bit sw, input int cnt, input logic [19:0] bits,
                              input logic [23:0] shifts);
        cfg_write(lgsr_pkg::REG_CLIP_X_LOW, 24'(xl));
        cfg_write(lgsr_pkg::REG_CLIP_X_HIGH, 24'(xh));
        cfg_write(lgsr_pkg::REG_CLIP_Y_LOW, 24'(yl));
        cfg_write(lgsr_pkg::REG_CLIP_Y_HIGH, 24'(yh));
        cfg_write(lgsr_pkg::REG_SWAP_AXES, 24'(sw));
        cfg_write(lgsr_pkg::REG_COMP_COUNT, 24'(cnt));
        cfg_write(lgsr_pkg::REG_COMP_WIDTH, 24'(bits));
        cfg_write(lgsr_pkg::REG_COMP_OFFSET, shifts);
    endtask

    // wait for every word to go in and every rectangle to come out
    task automatic drain();
        do @(negedge clk);
        while (word_queue.size() != 0 || in_ch.valid || pending_rects.size() != 0);
        repeat (400) @(posedge clk);
    endtask

    // one well-formed scanline with random content, now and then noise
    task automatic rand_scanline(input int yl, input int yh);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            push_cmd(lgsr_pkg::func_t'($urandom_range(0, 3)), 1);
            return;
        end
        repeat ($urandom_range(1, 4))
            push_load($urandom_range(0, 3), 31'($urandom), 31'($urandom_range(0, 15)),
                      $urandom);
        r = $urandom_range(0, 99);
        push_start((r < 80) ? 31'($urandom_range(1, 12)) : 31'($urandom),
                   (r < 90) ? $urandom_range(0, 60) - 30 : $urandom_range(0, 65535),
                   (r < 85) ? yl + int'($urandom_range(0, yh - yl))
                            : int'($urandom_range(0, 65535)));
        push_cmd(lgsr_pkg::FUNC_ADVANCE, $urandom_range(0, 10));
        if ($urandom_range(0, 9) == 0) push_load($urandom_range(0, 3), 31'($urandom),
                                                 31'($urandom), $urandom);
        push_cmd(lgsr_pkg::FUNC_ADVANCE, $urandom_range(0, 3));
        if ($urandom_range(0, 9) != 0) push_cmd(lgsr_pkg::FUNC_FINISH, 1);
        scanlines++;
    endtask

    task automatic rand_phase(input int count);
        int xl, yl, goal;
        xl = $urandom_range(0, 60) - 40;
        yl = $urandom_range(0, 100) - 50;
        set_config(xl, xl + $urandom_range(0, 80), yl, yl + $urandom_range(0, 20),
                   $urandom_range(0, 1), $urandom_range(0, 7),
                   20'($urandom), 24'($urandom));
        goal = words_sent + count;
        while (words_sent < goal)
        begin
            if (word_queue.size() < 8) rand_scanline(yl - 2, yl + 22);
            @(negedge clk);
        end
        drain();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.func = lgsr_pkg::FUNC_LOAD;
        in_ch.component_index = '0;
        in_ch.start_color = '0;
        in_ch.start_fraction = '0;
        in_ch.step_numerator = '0;
        in_ch.step_denominator = '0;
        in_ch.start_x = '0;
        in_ch.row = '0;
        in_ch.span_width = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = lgsr_pkg::REG_CLIP_X_LOW;
        cfg.data = '0;
        clip_xl = '0; clip_xh = '0; clip_yl = '0; clip_yh = '0;
        swap_xy = 1'b0; comp_count = 3'd1; comp_widths = 20'd8; comp_offsets = '0;
        for (int k = 0; k < 4; k++)
        begin
            colour_acc[k] = '0; rem_acc[k] = '0; step_num[k] = '0;
        end
        denom = 31'd1; pixel_pos = 0; run_start = 0; cur_row = 0;
        run_colour = '0; row_visible = 0;
        tx_gap = 0; rx_gap = 0; hold_arm = 0; burst = 0;
        errors = 0; words_sent = 0; rects_seen = 0; scanlines = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: finish and advance with no scanline started
        push_cmd(lgsr_pkg::FUNC_ADVANCE, 1);
        push_cmd(lgsr_pkg::FUNC_FINISH, 1);
        drain();

        set_config(-100, 100, -50, 50, 0, 4, {5'd8, 5'd8, 5'd8, 5'd8},
                   {6'd24, 6'd16, 6'd8, 6'd0});
        // extremes of colour, remainder and step; zero denominator
        push_load(0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_load(1, 31'h0, 31'h0, 32'h8000_0000);
        push_load(2, 31'h1234_5678, 31'd5, 32'hFFFF_FFFF);
        push_load(3, 31'h4000_0000, 31'd0, 32'h0100_0000);
        push_start(31'd0, -102, 0);
        push_cmd(lgsr_pkg::FUNC_ADVANCE, 4);
        push_load(0, 31'h0, 31'h0, 32'h0);
        push_cmd(lgsr_pkg::FUNC_ADVANCE, 1);
        push_cmd(lgsr_pkg::FUNC_FINISH, 1);
        // row outside the clip, then a run stuck at the largest column
        push_start(31'h7FFF_FFFF, 0, 51);
        push_cmd(lgsr_pkg::FUNC_ADVANCE, 2);
        push_cmd(lgsr_pkg::FUNC_FINISH, 1);
        push_start(31'd3, 32765, -50);
        push_cmd(lgsr_pkg::FUNC_ADVANCE, 4);
        push_cmd(lgsr_pkg::FUNC_FINISH, 1);
        drain();

        // widest clip, all fields at their top, swapped axes
        set_config(-32768, 32767, -32768, 32767, 1, 4, 20'hFFFFF, 24'hFFFFFF);
        push_load(0, 31'h7000_0000, 31'd1, 32'h8000_0000);
        push_start(31'd1, -32768, 32767);
        push_cmd(lgsr_pkg::FUNC_ADVANCE, 3);
        push_cmd(lgsr_pkg::FUNC_FINISH, 1);
        drain();

        // no components in use
        set_config(-10, 10, 0, 0, 0, 0, 20'h0, 24'h0);
        push_start(31'd2, -5, 0);
        push_cmd(lgsr_pkg::FUNC_ADVANCE, 2);
        push_cmd(lgsr_pkg::FUNC_FINISH, 1);
        drain();

        rand_phase(120);
        // hold the receiver for a long stretch while words keep coming
        @(negedge clk) hold_arm = 1;
        rand_phase(110);
        burst = 1;
        rand_phase(110);
        burst = 0;
        set_config(-20, 20, -3, 3, 0, 7, 20'($urandom), 24'($urandom));
        rand_phase(100);
        rand_phase(100);
        rand_phase(90);

        $display("%0d words sent, %0d scanlines, %0d rectangles checked",
                 words_sent, scanlines, rects_seen);
        $display("covered clip extremes, axis swap, component counts 0..7, pixel stalls");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d rectangles outstanding", pending_rects.size());
        $display("status: fail");
        $finish;
    end

endmodule
